[rtl/block_linear_deswizzle_address_macros.svh]
// Assertion macros shared by the block's checker.
`ifndef BLOCK_LINEAR_DESWIZZLE_ADDRESS_MACROS_SVH
`define BLOCK_LINEAR_DESWIZZLE_ADDRESS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checked across reset: the consequent must hold in the cycle after reset.
`define BLD_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

[rtl/bld_pkg.sv]
// Package with the field widths, register codes and shared types of the deswizzle block.
`default_nettype none

package bld_pkg;

   // Request and response field widths.
   localparam int X_BYTE_W  = 18;
   localparam int Y_ROW_W   = 14;
   localparam int Z_SLICE_W = 11;
   localparam int OFFSET_W  = 48;

   // Register widths.
   localparam int WIDTH_W  = 15;
   localparam int HEIGHT_W = 15;
   localparam int DEPTH_W  = 12;
   localparam int BPP_W    = 5;
   localparam int BHL_W    = 3;
   localparam int SIZE_W   = 48;

   // Register port.
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // Widths of the derived geometry values.
   localparam int ROW_BYTES_W = 19;
   localparam int BDL_W       = 3;
   localparam int WIG_W       = 13;
   localparam int PER_SLICE_W = 24;

   // Saturation limits applied on register writes.
   localparam logic [WIDTH_W-1:0]  MAX_WIDTH           = 15'd16384;
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT          = 15'd16384;
   localparam logic [DEPTH_W-1:0]  MAX_DEPTH           = 12'd2048;
   localparam logic [BPP_W-1:0]    MAX_BYTES_PER_PIXEL = 5'd16;
   localparam logic [BHL_W-1:0]    MAX_BLOCK_HEIGHT_LOG2 = 3'd5;

   // Register reset values.
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 15'd1;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 15'd1;
   localparam logic [DEPTH_W-1:0]  RESET_DEPTH  = 12'd1;
   localparam logic [BPP_W-1:0]    RESET_BPP    = 5'd4;
   localparam logic [BHL_W-1:0]    RESET_BHL    = 3'd4;
   localparam logic [SIZE_W-1:0]   RESET_SIZE   = 48'd0;

   // Register index, taken from the address bits above the 8-byte lane.
   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH       = 3'd0,
      REG_IMAGE_HEIGHT      = 3'd1,
      REG_IMAGE_DEPTH       = 3'd2,
      REG_BYTES_PER_PIXEL   = 3'd3,
      REG_BLOCK_HEIGHT_LOG2 = 3'd4,
      REG_SOURCE_SIZE       = 3'd5
   } reg_index_type;

   // Raw register contents.
   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [DEPTH_W-1:0]  depth;
      logic [BPP_W-1:0]    bpp;
      logic [BHL_W-1:0]    bhl;
      logic [SIZE_W-1:0]   source_size;
   } cfg_type;

   // Geometry seen by the address pipeline. The comment on each field gives
   // how many register stages it lags behind the registers.
   typedef struct packed {
      logic [HEIGHT_W-1:0]    height;     // 0
      logic [DEPTH_W-1:0]     depth;      // 0
      logic [BHL_W-1:0]       bhl;        // 0
      logic [ROW_BYTES_W-1:0] row_bytes;  // 1
      logic [BDL_W-1:0]       bdl;        // 1
      logic [WIG_W-1:0]       wig;        // 2
      logic [PER_SLICE_W-1:0] per_slice;  // 3, blocks per slice
      logic                   size_ok;    // 5
   } geom_type;

endpackage

`default_nettype wire

[rtl/bld_if.sv]
// Request and response channel interfaces of the deswizzle block.
`default_nettype none

interface bld_req_if;
   logic                           valid;
   logic                           ready;
   logic [bld_pkg::X_BYTE_W-1:0]   x_byte;
   logic [bld_pkg::Y_ROW_W-1:0]    y_row;
   logic [bld_pkg::Z_SLICE_W-1:0]  z_slice;

   modport source (output valid, output x_byte, output y_row, output z_slice, input ready);
   modport sink   (input valid, input x_byte, input y_row, input z_slice, output ready);
endinterface

interface bld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bld_pkg::OFFSET_W-1:0]  source_offset;
   logic [bld_pkg::OFFSET_W-1:0]  dest_offset;
   logic                          in_bounds;
   logic                          size_ok;

   modport source (output valid, output source_offset, output dest_offset,
                   output in_bounds, output size_ok, input ready);
   modport sink   (input valid, input source_offset, input dest_offset,
                   input in_bounds, input size_ok, output ready);
endinterface

`default_nettype wire

[rtl/block_linear_deswizzle_address.sv]
// Top level of the block-linear deswizzle address generator with its register file.
//
//   channel  direction  handshake            contents
//   req_ch   in         valid/ready          x_byte, y_row, z_slice
//   rsp_ch   out        valid/ready          source_offset, dest_offset, in_bounds, size_ok
//   csr_*    in/out     APB, pready tied 1   six geometry registers at 8-byte spacing
//
// One request is accepted every cycle unless a stall has filled every stage. Each request
// passes the six register stages of the address pipeline to give one response; the
// longest step is one multiply of up to 25 by 19 bits.
// Reset is synchronous and active high; it empties the pipeline and loads register defaults.
// A stalled response holds its stage; the stages behind it keep filling their empty slots,
// so requests are still taken until every stage is full.
// After a register write, every derived geometry value is ready before any request that
// follows the write reads it.
`default_nettype none

module block_linear_deswizzle_address (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bld_req_if.sink                                 req_ch,
   bld_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bld_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [bld_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [bld_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready
);

   // Register file. Every register sits in its own 64-bit lane, so the index is the
   // address above the lane offset.
   logic [bld_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [bld_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [bld_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic [bld_pkg::BPP_W-1:0]    bpp_ff, bpp_in;
   logic [bld_pkg::BHL_W-1:0]    bhl_ff, bhl_in;
   logic [bld_pkg::SIZE_W-1:0]   source_size_ff, source_size_in;

   logic                   write_en;
   bld_pkg::reg_index_type reg_index;
   bld_pkg::cfg_type       cfg;
   bld_pkg::geom_type      geom;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = bld_pkg::reg_index_type'(csr_paddr[5:3]);

   // Writes saturate each field but source size to its limit; unused indexes are dropped.
   always_comb begin
      width_in       = width_ff;
      height_in      = height_ff;
      depth_in       = depth_ff;
      bpp_in         = bpp_ff;
      bhl_in         = bhl_ff;
      source_size_in = source_size_ff;
      if (write_en) begin
         case (reg_index)
            bld_pkg::REG_IMAGE_WIDTH: begin
               width_in = (csr_pwdata[14:0] > bld_pkg::MAX_WIDTH) ?
                          bld_pkg::MAX_WIDTH : csr_pwdata[14:0];
            end
            bld_pkg::REG_IMAGE_HEIGHT: begin
               height_in = (csr_pwdata[14:0] > bld_pkg::MAX_HEIGHT) ?
                           bld_pkg::MAX_HEIGHT : csr_pwdata[14:0];
            end
            bld_pkg::REG_IMAGE_DEPTH: begin
               depth_in = (csr_pwdata[11:0] > bld_pkg::MAX_DEPTH) ?
                          bld_pkg::MAX_DEPTH : csr_pwdata[11:0];
            end
            bld_pkg::REG_BYTES_PER_PIXEL: begin
               bpp_in = (csr_pwdata[4:0] > bld_pkg::MAX_BYTES_PER_PIXEL) ?
                        bld_pkg::MAX_BYTES_PER_PIXEL : csr_pwdata[4:0];
            end
            bld_pkg::REG_BLOCK_HEIGHT_LOG2: begin
               bhl_in = (csr_pwdata[2:0] > bld_pkg::MAX_BLOCK_HEIGHT_LOG2) ?
                        bld_pkg::MAX_BLOCK_HEIGHT_LOG2 : csr_pwdata[2:0];
            end
            bld_pkg::REG_SOURCE_SIZE: begin
               source_size_in = csr_pwdata[47:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= bld_pkg::RESET_WIDTH;
         height_ff      <= bld_pkg::RESET_HEIGHT;
         depth_ff       <= bld_pkg::RESET_DEPTH;
         bpp_ff         <= bld_pkg::RESET_BPP;
         bhl_ff         <= bld_pkg::RESET_BHL;
         source_size_ff <= bld_pkg::RESET_SIZE;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         depth_ff       <= depth_in;
         bpp_ff         <= bpp_in;
         bhl_ff         <= bhl_in;
         source_size_ff <= source_size_in;
      end
   end

   // Reads return the stored, already saturated value.
   always_comb begin
      case (reg_index)
         bld_pkg::REG_IMAGE_WIDTH:       csr_prdata = {49'b0, width_ff};
         bld_pkg::REG_IMAGE_HEIGHT:      csr_prdata = {49'b0, height_ff};
         bld_pkg::REG_IMAGE_DEPTH:       csr_prdata = {52'b0, depth_ff};
         bld_pkg::REG_BYTES_PER_PIXEL:   csr_prdata = {59'b0, bpp_ff};
         bld_pkg::REG_BLOCK_HEIGHT_LOG2: csr_prdata = {61'b0, bhl_ff};
         bld_pkg::REG_SOURCE_SIZE:       csr_prdata = {16'b0, source_size_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   assign cfg = '{
      width:       width_ff,
      height:      height_ff,
      depth:       depth_ff,
      bpp:         bpp_ff,
      bhl:         bhl_ff,
      source_size: source_size_ff
   };

   // The geometry pipeline runs every cycle; the address pipeline reads each derived
   // value only at a stage that the value has already reached after a write.
   bld_geom u_geom (
      .clock (clock),
      .cfg   (cfg),
      .geom  (geom)
   );

   bld_pipe u_pipe (
      .clock  (clock),
      .reset  (reset),
      .geom   (geom),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

[rtl/bld_geom.sv]
// Free-running pipeline that derives the texture geometry from the registers.
`default_nettype none

module bld_geom (
   input  wire logic              clock,
   input  wire bld_pkg::cfg_type  cfg,
   output bld_pkg::geom_type      geom
);

   // Stage 1: row size, block depth code, block rows.
   logic [19:0] wb_prod;
   logic [12:0] depth_sum;
   logic [15:0] rows_per_block;
   logic [15:0] by_sum;
   logic [15:0] by_shift;
   logic [18:0] row_bytes_ff, row_bytes_in;
   logic [2:0]  bdl_ff, bdl_in;
   logic [11:0] blocks_y_ff, blocks_y_in;

   // Stage 2: width in GOBs and rounded depth.
   logic [19:0] wig_sum;
   logic [12:0] bd_m1;
   logic [12:0] dr_sum;
   logic [12:0] dr_quot;
   logic [12:0] dr_round;
   logic [12:0] wig_ff, wig_in;
   logic [11:0] depth_round_ff, depth_round_in;

   // Stage 3 to 5: blocks per slice, total size, size check.
   logic [24:0] ps_prod;
   logic [23:0] per_slice_ff, per_slice_in;
   logic [35:0] tprod_ff, tprod_in;
   logic [49:0] total;
   logic        size_ok_ff, size_ok_in;

   always_comb begin
      wb_prod     = {5'b0, cfg.width} * {15'b0, cfg.bpp};
      row_bytes_in = wb_prod[18:0];

      // Block depth is the largest of 16, 8, 4, 2 not above depth * 1.5, else 1.
      depth_sum = {1'b0, cfg.depth} + {2'b0, cfg.depth[11:1]};
      if (depth_sum >= 13'd16) begin
         bdl_in = 3'd4;
      end else if (depth_sum >= 13'd8) begin
         bdl_in = 3'd3;
      end else if (depth_sum >= 13'd4) begin
         bdl_in = 3'd2;
      end else if (depth_sum >= 13'd2) begin
         bdl_in = 3'd1;
      end else begin
         bdl_in = 3'd0;
      end

      rows_per_block = 16'd8 << cfg.bhl;
      by_sum         = {1'b0, cfg.height} + rows_per_block - 16'd1;
      by_shift       = by_sum >> ({1'b0, cfg.bhl} + 4'd3);
      blocks_y_in    = by_shift[11:0];

      wig_sum = {1'b0, row_bytes_ff} + 20'd63;
      wig_in  = wig_sum[18:6];

      bd_m1          = (13'd1 << bdl_ff) - 13'd1;
      dr_sum         = {1'b0, cfg.depth} + bd_m1;
      dr_quot        = dr_sum >> bdl_ff;
      dr_round       = dr_quot << bdl_ff;
      depth_round_in = dr_round[11:0];

      ps_prod      = {13'b0, blocks_y_ff} * {12'b0, wig_ff};
      per_slice_in = ps_prod[23:0];

      tprod_in = {12'b0, per_slice_ff} * {24'b0, depth_round_ff};

      // Every block row is padded to the full block height, every GOB is 512 bytes.
      total      = {14'b0, tprod_ff} << ({1'b0, cfg.bhl} + 4'd9);
      size_ok_in = {2'b0, cfg.source_size} >= total;
   end

   always_ff @(posedge clock) begin
      row_bytes_ff   <= row_bytes_in;
      bdl_ff         <= bdl_in;
      blocks_y_ff    <= blocks_y_in;
      wig_ff         <= wig_in;
      depth_round_ff <= depth_round_in;
      per_slice_ff   <= per_slice_in;
      tprod_ff       <= tprod_in;
      size_ok_ff     <= size_ok_in;
   end

   assign geom = '{
      height:    cfg.height,
      depth:     cfg.depth,
      bhl:       cfg.bhl,
      row_bytes: row_bytes_ff,
      bdl:       bdl_ff,
      wig:       wig_ff,
      per_slice: per_slice_ff,
      size_ok:   size_ok_ff
   };

endmodule

`default_nettype wire

[rtl/bld_pipe.sv]
// Six-stage address pipeline that turns a texel byte coordinate into both offsets.
`default_nettype none

module bld_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bld_pkg::geom_type geom,
   bld_req_if.sink                req_ch,
   bld_rsp_if.source              rsp_ch
);

   localparam int STAGES = 6;

   typedef struct packed {
      logic [17:0] x;
      logic [13:0] y;
      logic [10:0] z;
      logic [24:0] zh;
      logic        inb_yz;
   } s1_type;

   typedef struct packed {
      logic [17:0] x;
      logic [24:0] lin;
      logic        inb;
      logic [10:0] zb;
      logic [10:0] yb;
      logic [11:0] xg;
      logic [8:0]  lowp;
      logic [8:0]  ogob;
   } s2_type;

   typedef struct packed {
      logic [17:0] x;
      logic [43:0] dprod;
      logic [23:0] yw;
      logic [10:0] zb;
      logic [11:0] xg;
      logic [8:0]  lowp;
      logic [8:0]  ogob;
      logic        inb;
   } s3_type;

   typedef struct packed {
      logic [47:0] dst;
      logic [34:0] zp;
      logic [24:0] acc;
      logic [8:0]  lowp;
      logic [8:0]  ogob;
      logic        inb;
   } s4_type;

   typedef struct packed {
      logic [47:0] dst;
      logic [35:0] blk;
      logic [8:0]  lowp;
      logic [8:0]  ogob;
      logic        inb;
   } s5_type;

   typedef struct packed {
      logic [47:0] src;
      logic [47:0] dst;
      logic        inb;
      logic        size_ok;
   } s6_type;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_en;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [25:0] zh_prod;
   logic [4:0]  zmask;
   logic [3:0]  zlow;
   logic [13:0] y_blk;
   logic [5:0]  ymask;
   logic [4:0]  ygob;
   logic [3:0]  blk_shift;
   logic [47:0] blk_sh;
   logic [47:0] mid;
   logic [47:0] src_full;

   // A stage takes new contents when it is empty or its contents move on.
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_comb begin
      // Stage 1: capture, slice times height, row and slice bounds.
      zh_prod      = {15'b0, req_ch.z_slice} * {11'b0, geom.height};
      s1_in.x      = req_ch.x_byte;
      s1_in.y      = req_ch.y_row;
      s1_in.z      = req_ch.z_slice;
      s1_in.zh     = zh_prod[24:0];
      s1_in.inb_yz = ({1'b0, req_ch.y_row} < geom.height) &&
                     ({1'b0, req_ch.z_slice} < geom.depth);

      // Stage 2: linear row index, column bound, split of the coordinate into
      // block, GOB and in-GOB parts.
      zmask      = (5'd1 << geom.bdl) - 5'd1;
      zlow       = s1_ff.z[3:0] & zmask[3:0];
      y_blk      = s1_ff.y >> ({1'b0, geom.bhl} + 4'd3);
      ymask      = (6'd1 << geom.bhl) - 6'd1;
      ygob       = s1_ff.y[7:3] & ymask[4:0];
      s2_in.x    = s1_ff.x;
      s2_in.lin  = s1_ff.zh + {11'b0, s1_ff.y};
      s2_in.inb  = s1_ff.inb_yz && ({1'b0, s1_ff.x} < geom.row_bytes);
      s2_in.zb   = s1_ff.z >> geom.bdl;
      s2_in.yb   = y_blk[10:0];
      s2_in.xg   = s1_ff.x[17:6];
      // Slice within the block above GOB row within the block; they never overlap.
      s2_in.lowp = ({5'b0, zlow} << geom.bhl) | {4'b0, ygob};
      s2_in.ogob = {s1_ff.x[5], s1_ff.y[2:1], s1_ff.x[4], s1_ff.y[0], s1_ff.x[3:0]};

      // Stage 3: linear byte base and block row times width in GOBs.
      s3_in.x     = s2_ff.x;
      s3_in.dprod = {19'b0, s2_ff.lin} * {25'b0, geom.row_bytes};
      s3_in.yw    = {13'b0, s2_ff.yb} * {11'b0, geom.wig};
      s3_in.zb    = s2_ff.zb;
      s3_in.xg    = s2_ff.xg;
      s3_in.lowp  = s2_ff.lowp;
      s3_in.ogob  = s2_ff.ogob;
      s3_in.inb   = s2_ff.inb;

      // Stage 4: block slice times blocks per slice, linear offset done.
      s4_in.dst  = {4'b0, s3_ff.dprod} + {30'b0, s3_ff.x};
      s4_in.zp   = {24'b0, s3_ff.zb} * {11'b0, geom.per_slice};
      s4_in.acc  = {1'b0, s3_ff.yw} + {13'b0, s3_ff.xg};
      s4_in.lowp = s3_ff.lowp;
      s4_in.ogob = s3_ff.ogob;
      s4_in.inb  = s3_ff.inb;

      // Stage 5: block index.
      s5_in.dst  = s4_ff.dst;
      s5_in.blk  = {1'b0, s4_ff.zp} + {11'b0, s4_ff.acc};
      s5_in.lowp = s4_ff.lowp;
      s5_in.ogob = s4_ff.ogob;
      s5_in.inb  = s4_ff.inb;

      // Stage 6: place the block index above the in-block bits and mask.
      blk_shift     = {1'b0, geom.bhl} + {1'b0, geom.bdl};
      blk_sh        = {12'b0, s5_ff.blk} << blk_shift;
      mid           = blk_sh | {39'b0, s5_ff.lowp};
      src_full      = {mid[38:0], s5_ff.ogob};
      s6_in.src     = s5_ff.inb ? src_full : '0;
      s6_in.dst     = s5_ff.inb ? s5_ff.dst : '0;
      s6_in.inb     = s5_ff.inb;
      s6_in.size_ok = geom.size_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_ff <= s1_in;
      end
      if (stage_en[1]) begin
         s2_ff <= s2_in;
      end
      if (stage_en[2]) begin
         s3_ff <= s3_in;
      end
      if (stage_en[3]) begin
         s4_ff <= s4_in;
      end
      if (stage_en[4]) begin
         s5_ff <= s5_in;
      end
      if (stage_en[5]) begin
         s6_ff <= s6_in;
      end
   end

   assign req_ch.ready         = stage_en[0];
   assign rsp_ch.valid         = valid_ff[STAGES-1];
   assign rsp_ch.source_offset = s6_ff.src;
   assign rsp_ch.dest_offset   = s6_ff.dst;
   assign rsp_ch.in_bounds     = s6_ff.inb;
   assign rsp_ch.size_ok       = s6_ff.size_ok;

endmodule

`default_nettype wire

[rtl/bld_checker.sv]
// Port-level checker of the deswizzle block and its bind to the top level.
`default_nettype none
`include "block_linear_deswizzle_address_macros.svh"

module bld_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [bld_pkg::OFFSET_W-1:0]   rsp_source_offset,
   input wire logic [bld_pkg::OFFSET_W-1:0]   rsp_dest_offset,
   input wire logic                           rsp_in_bounds,
   input wire logic                           rsp_size_ok
);

   logic                                rsp_stall;
   logic                                rsp_oob;
   logic                                offsets_zero;
   logic                                req_free;
   logic [2*bld_pkg::OFFSET_W+1:0]      rsp_payload;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_oob      = rsp_valid && !rsp_in_bounds;
   assign offsets_zero = (rsp_source_offset == '0) && (rsp_dest_offset == '0);
   assign req_free     = req_ready || !req_valid || req_ready;
   assign rsp_payload  = {rsp_source_offset, rsp_dest_offset, rsp_in_bounds, rsp_size_ok};

   // A reset empties the pipeline.
   `BLD_ASSERT_AFTER_RESET(a_reset_empties, !rsp_valid, "response valid right after reset")

   // A waiting response keeps its contents.
   `BLD_ASSERT_NEXT(a_stall_holds, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // With the output stage free, every stage behind it can move, so requests are taken.
   `BLD_ASSERT_NOW(a_free_takes, !rsp_valid, req_ready && req_free, "request refused while output stage empty")

   // A coordinate outside the image gives zero offsets.
   `BLD_ASSERT_NOW(a_oob_zero, rsp_oob, offsets_zero, "out-of-bounds response with nonzero offset")

endmodule

bind block_linear_deswizzle_address bld_checker u_bld_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_source_offset (rsp_ch.source_offset),
   .rsp_dest_offset   (rsp_ch.dest_offset),
   .rsp_in_bounds     (rsp_ch.in_bounds),
   .rsp_size_ok       (rsp_ch.size_ok)
);

`default_nettype wire

[tb/sv/bld_addr_checker.sv]
// Checker that predicts and compares the responses of the deswizzle address block.
module bld_addr_checker
   import bld_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bld_req_if                    req_ch,
   bld_rsp_if                    rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    pending_results,
   output int                    mismatch_total
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] GOB_WIDTH = 64'd64;
   localparam logic [63:0] GOB_ROWS  = 64'd8;
   localparam logic [63:0] GOB_SIZE  = 64'd512;

   typedef struct packed {
      logic [OFFSET_W-1:0] source_offset;
      logic [OFFSET_W-1:0] dest_offset;
      logic                in_bounds;
      logic                size_ok;
   } texel_addrs_type;

   // Shadow copy of the geometry registers, kept from the writes seen on the bus.
   logic [63:0]     geo_width;
   logic [63:0]     geo_height;
   logic [63:0]     geo_depth;
   logic [63:0]     geo_bpp;
   logic [63:0]     geo_bhl;
   logic [63:0]     geo_source_size;
   texel_addrs_type expected_addrs[$];
   int              mismatches = 0;

   function automatic logic [63:0] saturate(logic [63:0] value, logic [63:0] ceiling);
      return (value > ceiling) ? ceiling : value;
   endfunction

   function automatic logic [63:0] div_up(logic [63:0] a, logic [63:0] d);
      return (a + d - 64'd1) / d;
   endfunction

   function automatic texel_addrs_type predict_texel_addrs(logic [63:0] x, logic [63:0] y,
                                                           logic [63:0] z);
      logic [63:0]     row_bytes;
      logic [63:0]     gobs_high;
      logic [63:0]     span;
      logic [63:0]     slab_depth;
      logic [63:0]     rows_per_block;
      logic [63:0]     block_bytes;
      logic [63:0]     gobs_wide;
      logic [63:0]     blocks_high;
      logic [63:0]     slice_bytes;
      logic [63:0]     depth_round;
      logic [63:0]     needed;
      logic [63:0]     xg;
      logic [63:0]     yg;
      logic [63:0]     swizzled;
      texel_addrs_type r;
      row_bytes = geo_width * geo_bpp;
      gobs_high = 64'd1 << geo_bhl;
      // Block depth follows the image depth, rounded with half a step of slack.
      span = geo_depth + geo_depth / 2;
      if (span >= 16) slab_depth = 16;
      else if (span >= 8) slab_depth = 8;
      else if (span >= 4) slab_depth = 4;
      else if (span >= 2) slab_depth = 2;
      else slab_depth = 1;
      rows_per_block = GOB_ROWS * gobs_high;
      block_bytes    = GOB_SIZE * gobs_high * slab_depth;
      gobs_wide      = div_up(row_bytes, GOB_WIDTH);
      blocks_high    = div_up(geo_height, rows_per_block);
      slice_bytes    = blocks_high * block_bytes * gobs_wide;
      depth_round    = div_up(geo_depth, slab_depth) * slab_depth;
      needed         = gobs_wide * blocks_high * gobs_high * depth_round * GOB_SIZE;
      r.size_ok       = (geo_source_size >= needed);
      r.in_bounds     = (x < row_bytes) && (y < geo_height) && (z < geo_depth);
      r.source_offset = '0;
      r.dest_offset   = '0;
      if (r.in_bounds) begin
         xg = x % GOB_WIDTH;
         yg = y % GOB_ROWS;
         swizzled = (z / slab_depth) * slice_bytes +
                    (z % slab_depth) * GOB_SIZE * gobs_high +
                    (y / rows_per_block) * block_bytes * gobs_wide +
                    ((y % rows_per_block) / GOB_ROWS) * GOB_SIZE +
                    (x / GOB_WIDTH) * block_bytes +
                    (xg / 32) * 256 + (yg / 2) * 64 + ((xg % 32) / 16) * 32 +
                    (yg % 2) * 16 + (xg % 16);
         r.source_offset = OFFSET_W'(swizzled);
         r.dest_offset   = OFFSET_W'(z * geo_height * row_bytes + y * row_bytes + x);
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h, actual %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      texel_addrs_type want;
      if (reset) begin
         geo_width       = 64'(RESET_WIDTH);
         geo_height      = 64'(RESET_HEIGHT);
         geo_depth       = 64'(RESET_DEPTH);
         geo_bpp         = 64'(RESET_BPP);
         geo_bhl         = 64'(RESET_BHL);
         geo_source_size = 64'(RESET_SIZE);
         expected_addrs.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_addrs.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request pending, expected none, %s %h %h %b %b",
                        $time, "actual", rsp_ch.source_offset, rsp_ch.dest_offset,
                        rsp_ch.in_bounds, rsp_ch.size_ok);
            end else begin
               want = expected_addrs.pop_front();
               check_field("source_offset", 64'(want.source_offset), 64'(rsp_ch.source_offset));
               check_field("dest_offset", 64'(want.dest_offset), 64'(rsp_ch.dest_offset));
               check_field("in_bounds", 64'(want.in_bounds), 64'(rsp_ch.in_bounds));
               check_field("size_ok", 64'(want.size_ok), 64'(rsp_ch.size_ok));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_addrs.push_back(predict_texel_addrs(64'(req_ch.x_byte),
                                                         64'(req_ch.y_row),
                                                         64'(req_ch.z_slice)));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]))
               REG_IMAGE_WIDTH:
                  geo_width = saturate(64'(csr_pwdata[WIDTH_W-1:0]), 64'(MAX_WIDTH));
               REG_IMAGE_HEIGHT:
                  geo_height = saturate(64'(csr_pwdata[HEIGHT_W-1:0]), 64'(MAX_HEIGHT));
               REG_IMAGE_DEPTH:
                  geo_depth = saturate(64'(csr_pwdata[DEPTH_W-1:0]), 64'(MAX_DEPTH));
               REG_BYTES_PER_PIXEL:
                  geo_bpp = saturate(64'(csr_pwdata[BPP_W-1:0]), 64'(MAX_BYTES_PER_PIXEL));
               REG_BLOCK_HEIGHT_LOG2:
                  geo_bhl = saturate(64'(csr_pwdata[BHL_W-1:0]), 64'(MAX_BLOCK_HEIGHT_LOG2));
               REG_SOURCE_SIZE:
                  geo_source_size = 64'(csr_pwdata[SIZE_W-1:0]);
               default: ;
            endcase
         end
      end
      pending_results <= expected_addrs.size();
      mismatch_total  <= mismatches;
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the deswizzle address testbench: clock, reset, stimulus and the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bld_pkg::*;

   // No new random phase starts once this many requests have gone in.
   localparam int ITEM_TARGET  = 1700;
   // Generous bound on the whole run, well above the slowest legal run.
   localparam int CYCLE_LIMIT  = 750000;
   // Six pipeline stages plus margin, to catch stray responses at the end.
   localparam int DRAIN_CYCLES = 12;
   // Register index that maps to no register; a write there must change nothing.
   localparam logic [2:0] REG_UNMAPPED = 3'd6;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  rsp_take       = 1'b0;
   logic                  steady_traffic = 1'b0;
   int                    rsp_hold       = 0;
   int                    cycle_count    = 0;
   int                    requests_sent  = 0;
   int                    pending_results;
   int                    mismatch_total;

   // The geometry as the stimulus sees it, used only to aim requests in and
   // around the image. It starts at the reset values of the registers.
   int                    geo_width  = 1;
   int                    geo_height = 1;
   int                    geo_depth  = 1;
   int                    geo_bpp    = 4;

   bld_req_if req_ch();
   bld_rsp_if rsp_ch();

   assign rsp_ch.ready = rsp_take;

   block_linear_deswizzle_address i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bld_addr_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .pending_results (pending_results),
      .mismatch_total  (mismatch_total)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Length of an idle stretch on either side. Most are short, a few run long,
   // and during a steady phase there are none at all.
   function automatic int idle_length();
      int r;
      if (steady_traffic) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // Response side: ready alternates between runs of acceptance and stalls of
   // random length, so back pressure lands on every pipeline stage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
         rsp_hold <= 0;
      end else if (steady_traffic) begin
         rsp_take <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_take <= 1'b1;
         rsp_hold <= $urandom_range(0, 8);
      end else begin
         rsp_take <= 1'b0;
         rsp_hold <= idle_length();
      end
   end

   // Watchdog: a run that hangs or loses responses ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // One register write: a setup cycle, then an access cycle whose closing edge
   // performs the write. The bus goes idle at that same edge.
   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offers one request and waits for the handshake. Valid stays high when the
   // next request follows at once, and is lowered only for a real gap, so it is
   // never dropped and raised within one step.
   task automatic send_request(input logic [63:0] x, input logic [63:0] y,
                               input logic [63:0] z);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.x_byte  <= X_BYTE_W'(x);
      req_ch.y_row   <= Y_ROW_W'(y);
      req_ch.z_slice <= Z_SLICE_W'(z);
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      requests_sent++;
      gap = idle_length();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops the request side and waits until every response has come back, so
   // the registers can be rewritten while the block is idle.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Raw bus value for a register. Now and then bits above the field width are
   // set, which the block must drop, and a value at the ceiling is sometimes
   // replaced by a larger one that the block must saturate back to the ceiling.
   function automatic logic [63:0] encode_register(int unsigned value, int unsigned width,
                                                   int unsigned ceiling);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 64'(value) | ({$urandom, $urandom} << width);
      if (r == 1 && value == ceiling)
         return 64'($urandom_range(ceiling, (1 << width) - 1));
      return 64'(value);
   endfunction

   // Image extent for a random phase: mostly small, now and then anywhere up to
   // the ceiling, and rarely exactly zero or exactly the ceiling.
   function automatic int unsigned pick_extent(int unsigned small_max, int unsigned ceiling,
                                               bit wide);
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 0;
      if (r == 1) return ceiling;
      if (wide) return $urandom_range(1, ceiling);
      return $urandom_range(1, small_max);
   endfunction

   // Rewrites a random subset of the geometry registers.
   task automatic program_random_geometry();
      bit          wide;
      int unsigned bhl;
      logic [63:0] size;
      wide = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) != 0) begin
         geo_width = pick_extent(40, MAX_WIDTH, wide);
         csr_write(REG_IMAGE_WIDTH, encode_register(geo_width, WIDTH_W, MAX_WIDTH));
      end
      if ($urandom_range(0, 4) != 0) begin
         geo_height = pick_extent(40, MAX_HEIGHT, wide);
         csr_write(REG_IMAGE_HEIGHT, encode_register(geo_height, HEIGHT_W, MAX_HEIGHT));
      end
      if ($urandom_range(0, 4) != 0) begin
         geo_depth = pick_extent(12, MAX_DEPTH, wide);
         csr_write(REG_IMAGE_DEPTH, encode_register(geo_depth, DEPTH_W, MAX_DEPTH));
      end
      if ($urandom_range(0, 4) != 0) begin
         geo_bpp = pick_extent(MAX_BYTES_PER_PIXEL, MAX_BYTES_PER_PIXEL, 1'b0);
         csr_write(REG_BYTES_PER_PIXEL,
                   encode_register(geo_bpp, BPP_W, MAX_BYTES_PER_PIXEL));
      end
      if ($urandom_range(0, 4) != 0) begin
         bhl = $urandom_range(0, MAX_BLOCK_HEIGHT_LOG2);
         csr_write(REG_BLOCK_HEIGHT_LOG2,
                   encode_register(bhl, BHL_W, MAX_BLOCK_HEIGHT_LOG2));
      end
      if ($urandom_range(0, 4) != 0) begin
         // Small images need a whole number of GOBs, so sizes near a power of
         // two times one GOB sit right on the boundary of the size check.
         case ($urandom_range(0, 6))
            0: size = 64'd0;
            1: size = 64'd512 << $urandom_range(0, 8);
            2: size = (64'd512 << $urandom_range(0, 8)) - 64'd1;
            3: size = 64'($urandom_range(0, 1 << 22));
            4: size = {$urandom, $urandom};
            5: size = 64'h0000_FFFF_FFFF_FFFF;
            default: size = (64'd512 << $urandom_range(0, 8)) + 64'd1;
         endcase
         csr_write(REG_SOURCE_SIZE, size);
      end
      if ($urandom_range(0, 15) == 0) csr_write(REG_UNMAPPED, {$urandom, $urandom});
   endtask

   // One random request: mostly inside the image, some just past one edge of
   // it, and some with every field random across its full width.
   task automatic send_texel();
      int unsigned span_x;
      int unsigned edge_dim;
      int          r;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] z;
      span_x = geo_width * geo_bpp;
      r = $urandom_range(0, 99);
      if (r < 85 && span_x != 0 && geo_height != 0 && geo_depth != 0) begin
         x = $urandom_range(0, span_x - 1);
         y = $urandom_range(0, geo_height - 1);
         z = $urandom_range(0, geo_depth - 1);
      end else if (r < 93) begin
         edge_dim = $urandom_range(0, 2);
         x = (edge_dim == 0 || span_x == 0) ? span_x : $urandom_range(0, span_x - 1);
         y = (edge_dim == 1 || geo_height == 0) ? geo_height
                                                : $urandom_range(0, geo_height - 1);
         z = (edge_dim == 2 || geo_depth == 0) ? geo_depth
                                               : $urandom_range(0, geo_depth - 1);
      end else begin
         x = $urandom;
         y = $urandom;
         z = $urandom;
      end
      send_request(x, y, z);
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.x_byte  <= '0;
      req_ch.y_row   <= '0;
      req_ch.z_slice <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: one 4-byte texel in a 1x1x1 image. The first request
      // hits byte zero, the second the last byte of the texel, and the rest
      // step just past each edge, ending with every field at its maximum.
      send_request(0, 0, 0);
      send_request(3, 0, 0);
      send_request(4, 0, 0);
      send_request(0, 1, 0);
      send_request(0, 0, 1);
      send_request(262143, 16383, 2047);
      drain_responses();

      // Largest image, tallest blocks and the largest source buffer. The
      // requests sit on GOB and half-GOB borders and at the far corner.
      csr_write(REG_IMAGE_WIDTH, 64'(MAX_WIDTH));
      csr_write(REG_IMAGE_HEIGHT, 64'(MAX_HEIGHT));
      csr_write(REG_IMAGE_DEPTH, 64'(MAX_DEPTH));
      csr_write(REG_BYTES_PER_PIXEL, 64'(MAX_BYTES_PER_PIXEL));
      csr_write(REG_BLOCK_HEIGHT_LOG2, 64'(MAX_BLOCK_HEIGHT_LOG2));
      csr_write(REG_SOURCE_SIZE, 64'h0000_FFFF_FFFF_FFFF);
      geo_width  = MAX_WIDTH;
      geo_height = MAX_HEIGHT;
      geo_depth  = MAX_DEPTH;
      geo_bpp    = MAX_BYTES_PER_PIXEL;
      send_request(262143, 16383, 2047);
      send_request(0, 0, 0);
      send_request(63, 7, 0);
      send_request(64, 8, 1);
      send_request(31, 1, 2);
      send_request(32, 2, 3);
      send_request(15, 3, 0);
      send_request(16, 4, 17);
      drain_responses();

      // Writes past the ceilings saturate, bits above each field are dropped,
      // and a write to the unmapped index leaves everything alone. The source
      // size keeps only its low 48 bits, which leave a single GOB here.
      csr_write(REG_IMAGE_WIDTH, 64'h7FFF);
      csr_write(REG_IMAGE_HEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_IMAGE_DEPTH, 64'hFFF);
      csr_write(REG_BYTES_PER_PIXEL, 64'h1F);
      csr_write(REG_BLOCK_HEIGHT_LOG2, 64'h7);
      csr_write(REG_SOURCE_SIZE, 64'hFFFF_0000_0000_0200);
      csr_write(REG_UNMAPPED, 64'h0000_0000_0000_0001);
      send_request(262143, 16383, 2047);
      send_request(0, 0, 0);
      send_request(100000, 9000, 1500);
      drain_responses();

      // Zero width: the written value survives only as zero after masking, so
      // every coordinate falls outside and the size check holds trivially.
      csr_write(REG_IMAGE_WIDTH, 64'h8000);
      geo_width = 0;
      send_request(0, 0, 0);
      send_request(1, 2, 3);
      drain_responses();

      // Random phases: a new geometry, then a burst of requests, then a full
      // drain before the next geometry. About one phase in four runs with no
      // idle cycles on either side.
      while (requests_sent < ITEM_TARGET) begin
         steady_traffic <= ($urandom_range(0, 3) == 0);
         program_random_geometry();
         repeat ($urandom_range(20, 80)) send_texel();
         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/bld_pkg.sv
rtl/bld_if.sv
rtl/bld_geom.sv
rtl/bld_pipe.sv
rtl/block_linear_deswizzle_address.sv
rtl/bld_checker.sv
tb/sv/bld_addr_checker.sv
tb/sv/tb_top.sv
